>>> sv/lfst_pkg.sv
// shared constants, codes and transaction types of the lowest free slot table
`default_nettype none

package lfst_pkg;

    localparam int SLOTS     = 256;
    localparam int GRP_SZ    = 16;
    localparam int BIT_W     = $clog2(GRP_SZ);
    localparam int NGRP      = (SLOTS + GRP_SZ - 1) / GRP_SZ;
    localparam int SLOTS_PAD = NGRP * GRP_SZ;
    localparam int IDX_W     = $clog2(SLOTS_PAD);
    localparam int GRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ENTRY_W   = 64;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_NOT_OCCUPIED = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic [31:0] position;
        logic [15:0] taxon;
        logic [15:0] body_handle;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  slot_out;
        logic        entry_valid;
        logic [31:0] position_out;
        logic [15:0] taxon_out;
        logic [15:0] body_out;
        logic [8:0]  live_count;
        logic [1:0]  status;
    } out_item_t;

    // control from the sequencer to the occupancy map
    typedef struct packed {
        logic             start;
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } occ_cmd_t;

    // status from the occupancy map
    typedef struct packed {
        logic             any_free;
        logic [IDX_W-1:0] free_idx;
        logic             idx_occ;
        logic [CNT_W-1:0] count;
    } occ_stat_t;

endpackage

`default_nettype wire

>>> sv/lfst_ram.sv
// generic single write port, single read port ram with registered read data
`default_nettype none

module lfst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/lfst_occ.sv
// occupancy bits, live count and two-level lowest free slot search
`default_nettype none

module lfst_occ (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lfst_pkg::occ_cmd_t cmd,
    output lfst_pkg::occ_stat_t    stat
);

    localparam int PAD_CNT = lfst_pkg::SLOTS_PAD - lfst_pkg::SLOTS;
    // slots past the table end look permanently taken
    localparam logic [lfst_pkg::SLOTS_PAD-1:0] PAD_MASK =
        {lfst_pkg::SLOTS_PAD{1'b1}} << lfst_pkg::SLOTS;

    logic [lfst_pkg::SLOTS_PAD-1:0] occ_reg, occ_next;
    logic [lfst_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [lfst_pkg::GRP_W-1:0]     grp_sel_reg, grp_sel_next;
    logic                           any_free_reg, any_free_next;

    logic [lfst_pkg::NGRP-1:0]   grp_full;
    logic [lfst_pkg::GRP_W-1:0]  grp_pick;
    logic [lfst_pkg::GRP_SZ-1:0] grp_bits;
    logic [lfst_pkg::BIT_W-1:0]  bit_pick;

    // first level: one full flag per group, lowest group with a hole
    always_comb
    begin
        grp_pick = '0;
        for (int g = 0; g < lfst_pkg::NGRP; g++)
        begin
            grp_full[g] = &occ_reg[g*lfst_pkg::GRP_SZ +: lfst_pkg::GRP_SZ];
        end
        for (int g = lfst_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (!grp_full[g])
            begin
                grp_pick = lfst_pkg::GRP_W'(g);
            end
        end
    end

    // second level: lowest free bit inside the registered group
    always_comb
    begin
        grp_bits = occ_reg[int'(grp_sel_reg)*lfst_pkg::GRP_SZ +: lfst_pkg::GRP_SZ];
        bit_pick = '0;
        for (int b = lfst_pkg::GRP_SZ - 1; b >= 0; b--)
        begin
            if (!grp_bits[b])
            begin
                bit_pick = lfst_pkg::BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        occ_next      = occ_reg;
        count_next    = count_reg;
        grp_sel_next  = grp_sel_reg;
        any_free_next = any_free_reg;
        if (cmd.start)
        begin
            grp_sel_next  = grp_pick;
            any_free_next = !(&grp_full);
        end
        if (cmd.set)
        begin
            occ_next[cmd.idx] = 1'b1;
            count_next        = count_reg + lfst_pkg::CNT_W'(1);
        end
        else if (cmd.clr)
        begin
            occ_next[cmd.idx] = 1'b0;
            count_next        = count_reg - lfst_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= PAD_MASK;
            count_reg    <= '0;
            grp_sel_reg  <= '0;
            any_free_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            count_reg    <= count_next;
            grp_sel_reg  <= grp_sel_next;
            any_free_reg <= any_free_next;
        end
    end

    assign stat.any_free = any_free_reg;
    assign stat.free_idx = lfst_pkg::IDX_W'({grp_sel_reg, bit_pick});
    assign stat.idx_occ  = occ_reg[cmd.idx];
    assign stat.count    = count_reg;

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == int'(count_reg) + PAD_CNT)
        else $error("live count disagrees with occupancy map");

    a_set_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set |-> !occ_reg[cmd.idx])
        else $error("allocation of a slot that is already taken");

    a_clr_on_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> occ_reg[cmd.idx] && int'(cmd.idx) < lfst_pkg::SLOTS)
        else $error("release of a slot that is not taken");

endmodule

`default_nettype wire

>>> sv/lowest_free_slot_table.sv
// lowest free slot table: insert into lowest free slot, remove and read by slot
//
// input channel in_valid/in_ready/in_data carries one request transaction:
// action insert stores position, taxon and body handle in the lowest free slot,
// action remove frees a slot, action read returns a slot's contents.
// output channel out_valid/out_ready/out_data carries exactly one result per
// request, in order, with the live count after the request and a status code
// (table full on insert, slot not occupied on remove).
// the acceptance cycle reads the entry memory and picks the lowest group with a
// free slot; in S_DONE, once the output register is free, the free bit in that
// group is picked and memory, occupancy and the output register are written.
// no new request is accepted until the current one leaves S_DONE; the entry
// memory and occupancy map serve one request at a time.
// the result sits in an output register, so in_ready rises again while it
// waits; a stalled receiver holds the next request in S_DONE.
// reset clears the occupancy map and live count at once; entry data are only
// returned from slots written by an insert, so the memory needs no clearing.
`default_nettype none

module lowest_free_slot_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lfst_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lfst_pkg::out_item_t      out_data
);

    typedef enum logic {
        S_IDLE,
        S_DONE
    } state_t;

    state_t               state_reg;
    lfst_pkg::in_item_t   item_reg;
    logic                 out_valid_reg;
    lfst_pkg::out_item_t  out_data_reg;

    lfst_pkg::occ_cmd_t   occ_cmd;
    lfst_pkg::occ_stat_t  occ_stat;
    logic [lfst_pkg::ENTRY_W-1:0] rd_entry;

    logic                 accept;
    logic                 finish;
    logic                 in_range;
    logic                 live;
    logic                 ins_ok;
    logic                 rem_ok;
    logic [8:0]           count_ext;
    lfst_pkg::out_item_t  result;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign in_range  = 9'(item_reg.slot) < 9'(lfst_pkg::SLOTS);
    assign live      = in_range && occ_stat.idx_occ;
    assign ins_ok    = (item_reg.action == lfst_pkg::ACT_INSERT) && occ_stat.any_free;
    assign rem_ok    = (item_reg.action == lfst_pkg::ACT_REMOVE) && live;
    assign count_ext = 9'(occ_stat.count);

    always_comb
    begin
        occ_cmd.start = accept;
        occ_cmd.set   = finish && ins_ok;
        occ_cmd.clr   = finish && rem_ok;
        if (item_reg.action == lfst_pkg::ACT_INSERT)
        begin
            occ_cmd.idx = occ_stat.free_idx;
        end
        else
        begin
            occ_cmd.idx = item_reg.slot[lfst_pkg::IDX_W-1:0];
        end
    end

    lfst_occ u_occ (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (occ_cmd),
        .stat  (occ_stat)
    );

    lfst_ram #(
        .DEPTH (lfst_pkg::SLOTS),
        .WIDTH (lfst_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (finish && ins_ok),
        .waddr (occ_stat.free_idx[lfst_pkg::ADDR_W-1:0]),
        .wdata ({item_reg.position, item_reg.taxon, item_reg.body_handle}),
        .re    (accept),
        .raddr (in_data.slot[lfst_pkg::ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    always_comb
    begin
        result              = '0;
        result.slot_out     = item_reg.slot;
        result.live_count   = count_ext;
        result.status       = lfst_pkg::ST_OK;
        case (item_reg.action)
            lfst_pkg::ACT_INSERT:
            begin
                if (occ_stat.any_free)
                begin
                    result.slot_out    = 8'(occ_stat.free_idx);
                    result.entry_valid = 1'b1;
                    result.live_count  = count_ext + 9'd1;
                end
                else
                begin
                    result.slot_out = '0;
                    result.status   = lfst_pkg::ST_FULL;
                end
            end
            lfst_pkg::ACT_REMOVE:
            begin
                if (live)
                begin
                    result.live_count = count_ext - 9'd1;
                end
                else
                begin
                    result.status = lfst_pkg::ST_NOT_OCCUPIED;
                end
            end
            lfst_pkg::ACT_READ:
            begin
                if (live)
                begin
                    result.entry_valid  = 1'b1;
                    result.position_out = rd_entry[63:32];
                    result.taxon_out    = rd_entry[31:16];
                    result.body_out     = rd_entry[15:0];
                end
            end
            default:
            begin
                result.entry_valid = live;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (finish)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_full_means_all_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == lfst_pkg::ST_FULL
        |-> out_data.live_count == 9'(lfst_pkg::SLOTS))
        else $error("table full reported with free slots left");

    a_data_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.position_out != '0 || out_data.taxon_out != '0
                      || out_data.body_out != '0)
        |-> out_data.entry_valid)
        else $error("entry data returned for an unoccupied slot");

    a_no_overwrite_pending: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> state_reg == S_DONE && !(out_valid_reg && !out_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

>>> sim/tb_lowest_free_slot_table.sv
// self-checking testbench for the lowest free slot table
module tb_lowest_free_slot_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_CYCLES = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    lfst_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lfst_pkg::out_item_t out_data;

    // shadow copy of the table, updated as each request transaction is accepted
    bit          occ_map [lfst_pkg::SLOTS];
    logic [31:0] pos_mem [lfst_pkg::SLOTS];
    logic [15:0] taxon_mem [lfst_pkg::SLOTS];
    logic [15:0] body_mem [lfst_pkg::SLOTS];
    logic [8:0]  live_slots = '0;

    lfst_pkg::out_item_t pending_results [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;
    bit        stall_req = 1'b0;

    lowest_free_slot_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #6 clk = ~clk;

    function automatic lfst_pkg::out_item_t predict_slot_op(input lfst_pkg::in_item_t req);
        lfst_pkg::out_item_t r;
        int free_idx;
        r = '0;
        r.slot_out = req.slot;
        r.status = lfst_pkg::ST_OK;
        free_idx = -1;
        case (req.action)
            lfst_pkg::ACT_INSERT:
            begin
                for (int i = 0; i < lfst_pkg::SLOTS; i++)
                    if (free_idx < 0 && !occ_map[i])
                        free_idx = i;
                if (free_idx >= 0)
                begin
                    occ_map[free_idx] = 1'b1;
                    pos_mem[free_idx] = req.position;
                    taxon_mem[free_idx] = req.taxon;
                    body_mem[free_idx] = req.body_handle;
                    live_slots = live_slots + 1'b1;
                    r.slot_out = free_idx[7:0];
                    r.entry_valid = 1'b1;
                end
                else
                begin
                    r.slot_out = '0;
                    r.status = lfst_pkg::ST_FULL;
                end
            end
            lfst_pkg::ACT_REMOVE:
            begin
                if (occ_map[req.slot])
                begin
                    occ_map[req.slot] = 1'b0;
                    live_slots = live_slots - 1'b1;
                end
                else
                    r.status = lfst_pkg::ST_NOT_OCCUPIED;
            end
            lfst_pkg::ACT_READ:
            begin
                if (occ_map[req.slot])
                begin
                    r.entry_valid = 1'b1;
                    r.position_out = pos_mem[req.slot];
                    r.taxon_out = taxon_mem[req.slot];
                    r.body_out = body_mem[req.slot];
                end
            end
            default:
                r.entry_valid = occ_map[req.slot];
        endcase
        r.live_count = live_slots;
        return r;
    endfunction

    // offers one transaction, holds it until accepted, then records its expected result
    task automatic send_request(input lfst_pkg::in_item_t req);
        lfst_pkg::out_item_t expected;
        if (!quiet && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected = predict_slot_op(req);
        pending_results.insert(pending_results.size(), expected);
    endtask

    function automatic lfst_pkg::in_item_t make_request(input logic [1:0] act,
                                                        input logic [7:0] slot);
        lfst_pkg::in_item_t req;
        req.action = act;
        req.slot = slot;
        req.position = $urandom;
        req.taxon = 16'($urandom_range(0, 65535));
        req.body_handle = 16'($urandom_range(0, 65535));
        return req;
    endfunction

    function automatic logic [7:0] pick_slot();
        int live [$];
        if ($urandom_range(99) < 20)
            return 8'($urandom_range(0, lfst_pkg::SLOTS - 1));
        for (int i = 0; i < lfst_pkg::SLOTS; i++)
            if (occ_map[i])
                live.insert(live.size(), i);
        if (live.size() == 0)
            return 8'($urandom_range(0, lfst_pkg::SLOTS - 1));
        return 8'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function automatic lfst_pkg::in_item_t make_random_request(input int insert_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < insert_pct)
            return make_request(lfst_pkg::ACT_INSERT, 8'($urandom_range(0, 255)));
        else if (roll < insert_pct + (95 - insert_pct) / 2)
            return make_request(lfst_pkg::ACT_REMOVE, pick_slot());
        else if (roll < 95)
            return make_request(lfst_pkg::ACT_READ, pick_slot());
        return make_request(ACT_UNUSED, pick_slot());
    endfunction

    task automatic send_fixed(input logic [1:0] act, input logic [7:0] slot,
                              input logic [31:0] pos, input logic [15:0] tax,
                              input logic [15:0] body);
        lfst_pkg::in_item_t req;
        req.action = act;
        req.slot = slot;
        req.position = pos;
        req.taxon = tax;
        req.body_handle = body;
        send_request(req);
    endtask

    task automatic test_directed();
        send_fixed(lfst_pkg::ACT_READ, 8'd0, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd0, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd255, '1, '1, '1);
        send_fixed(lfst_pkg::ACT_READ, 8'd255, '1, '1, '1);
        send_fixed(lfst_pkg::ACT_INSERT, 8'd0, 32'h0, 16'h0, 16'h0);
        send_fixed(lfst_pkg::ACT_INSERT, 8'hff, 32'hffff_ffff, 16'hffff, 16'hffff);
        send_fixed(lfst_pkg::ACT_INSERT, 8'h5a, 32'ha5a5_5a5a, 16'h8001, 16'h7ffe);
        send_fixed(lfst_pkg::ACT_READ, 8'd0, '1, '1, '1);
        send_fixed(lfst_pkg::ACT_READ, 8'd1, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_READ, 8'd2, '0, '0, '0);
        send_fixed(ACT_UNUSED, 8'd1, '1, '1, '1);
        send_fixed(ACT_UNUSED, 8'd200, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd1, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_READ, 8'd1, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd1, '0, '0, '0);
        // freed slot 1 is the lowest hole again
        send_fixed(lfst_pkg::ACT_INSERT, 8'd77, 32'h1234_5678, 16'h00ff, 16'hff00);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd0, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_REMOVE, 8'd2, '0, '0, '0);
        send_fixed(lfst_pkg::ACT_INSERT, 8'd3, 32'h8000_0000, 16'h8000, 16'h0001);
        send_fixed(lfst_pkg::ACT_READ, 8'd0, '0, '0, '0);
    endtask

    task automatic test_fill_to_full();
        quiet = 1'b1;
        while (live_slots < lfst_pkg::SLOTS)
            send_request(make_request(lfst_pkg::ACT_INSERT, 8'($urandom_range(0, 255))));
        repeat (4)
            send_request(make_request(lfst_pkg::ACT_INSERT, 8'($urandom_range(0, 255))));
        send_request(make_request(lfst_pkg::ACT_READ, 8'd255));
        send_request(make_request(ACT_UNUSED, 8'd255));
        send_request(make_request(lfst_pkg::ACT_REMOVE, 8'd255));
        send_request(make_request(lfst_pkg::ACT_REMOVE, 8'd128));
        send_request(make_request(lfst_pkg::ACT_INSERT, 8'd0));
        send_request(make_request(lfst_pkg::ACT_INSERT, 8'd0));
        send_request(make_request(lfst_pkg::ACT_INSERT, 8'd0));
        quiet = 1'b0;
    endtask

    task automatic test_receiver_stall();
        stall_req = 1'b1;
        repeat (40) send_request(make_random_request(35));
    endtask

    task automatic test_random_churn(input int n, input int insert_pct);
        repeat (n) send_request(make_random_request(insert_pct));
    endtask

    task automatic test_drain_to_empty();
        while (live_slots != 0)
        begin
            if ($urandom_range(99) < 25)
                send_request(make_request(lfst_pkg::ACT_READ, pick_slot()));
            else
                send_request(make_request(lfst_pkg::ACT_REMOVE, pick_slot()));
        end
        repeat (4)
            send_request(make_request(lfst_pkg::ACT_REMOVE, 8'($urandom_range(0, 255))));
        send_request(make_request(lfst_pkg::ACT_READ, 8'($urandom_range(0, 255))));
    endtask

    // receiver: random backpressure, always ready while quiet, or a long hold-off when a test asks for one
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        lfst_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected: %p", out_data);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_data.slot_out !== exp_r.slot_out)
                begin
                    $error("slot_out exp %0d got %0d", exp_r.slot_out, out_data.slot_out);
                    error_count++;
                end
                if (out_data.entry_valid !== exp_r.entry_valid)
                begin
                    $error("entry_valid exp %0d got %0d", exp_r.entry_valid,
                           out_data.entry_valid);
                    error_count++;
                end
                if (out_data.position_out !== exp_r.position_out)
                begin
                    $error("position_out exp %h got %h", exp_r.position_out,
                           out_data.position_out);
                    error_count++;
                end
                if (out_data.taxon_out !== exp_r.taxon_out)
                begin
                    $error("taxon_out exp %h got %h", exp_r.taxon_out, out_data.taxon_out);
                    error_count++;
                end
                if (out_data.body_out !== exp_r.body_out)
                begin
                    $error("body_out exp %h got %h", exp_r.body_out, out_data.body_out);
                    error_count++;
                end
                if (out_data.live_count !== exp_r.live_count)
                begin
                    $error("live_count exp %0d got %0d", exp_r.live_count,
                           out_data.live_count);
                    error_count++;
                end
                if (out_data.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, out_data.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_to_full();
        test_receiver_stall();
        test_random_churn(600, 40);
        test_drain_to_empty();
        test_random_churn(600, 55);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
sv/lfst_pkg.sv
sv/lfst_ram.sv
sv/lfst_occ.sv
sv/lowest_free_slot_table.sv
sim/tb_lowest_free_slot_table.sv
